// ===== design/lpst_pkg.sv =====
// shared constants, types and codes for the lazy proximal soft-threshold core
package lpst_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_REPEAT = 65535;

    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 48;
    localparam int REPEAT_W   = 16;
    localparam int THRESH_W   = 31;
    localparam int DECAY_W    = FRAC_BITS + 1;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = $clog2(MAX_REPEAT + 1);

    // magnitude after the shrink, and its product with the decay factor
    localparam int MAG_W      = VALUE_W + 1;
    localparam int PROD_W     = MAG_W + DECAY_W;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;

    localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = CFG_IDX_W'(2);

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE = 2'd0,
        MODE_L1   = 2'd1,
        MODE_L2   = 2'd2,
        MODE_EN   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOFT,
        ST_MUL,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic soft_en;
        logic mul_en;
        logic acc_en;
        logic out_load;
    } cmd_t;

endpackage

// ===== design/lpst_ctrl.sv =====
// step sequencer: input/output handshakes, repeat counter and datapath commands
module lpst_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lpst_pkg::REPEAT_W-1:0]  repeat_count,
    input  logic                           want_average,
    input  lpst_pkg::mode_t                mode,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lpst_pkg::cmd_t                 cmd
);

    lpst_pkg::state_t            state_reg, state_next;
    logic [lpst_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        first_reg, first_next;
    logic                        avg_reg, avg_next;
    logic                        out_valid_reg, out_valid_next;
    logic [lpst_pkg::CNT_W-1:0]  count_load;
    logic                        in_xfer;
    logic                        out_free;

    assign in_xfer  = in_valid && (state_reg == lpst_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (mode == lpst_pkg::MODE_NONE)
        begin
            count_load = '0;
        end
        else if (32'(repeat_count) > 32'(lpst_pkg::MAX_REPEAT))
        begin
            count_load = lpst_pkg::CNT_W'(lpst_pkg::MAX_REPEAT);
        end
        else
        begin
            count_load = lpst_pkg::CNT_W'(repeat_count);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpst_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (count_load == '0) ? lpst_pkg::ST_FINISH : lpst_pkg::ST_SOFT;
                end
            end
            lpst_pkg::ST_SOFT:
            begin
                state_next = lpst_pkg::ST_MUL;
            end
            lpst_pkg::ST_MUL:
            begin
                state_next = (count_reg == lpst_pkg::CNT_W'(1)) ? lpst_pkg::ST_FINISH
                                                                 : lpst_pkg::ST_SOFT;
            end
            lpst_pkg::ST_FINISH:
            begin
                state_next = lpst_pkg::ST_EMIT;
            end
            lpst_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lpst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpst_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        count_next = count_reg;
        first_next = first_reg;
        avg_next   = avg_reg;
        case (state_reg)
            lpst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_xfer)
                begin
                    cmd.load   = 1'b1;
                    count_next = count_load;
                    first_next = 1'b1;
                    avg_next   = want_average;
                end
            end
            lpst_pkg::ST_SOFT:
            begin
                // fold the previous step's value into the sum while shrinking
                cmd.soft_en = 1'b1;
                cmd.acc_en  = avg_reg && !first_reg;
                first_next  = 1'b0;
            end
            lpst_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                count_next = count_reg - lpst_pkg::CNT_W'(1);
            end
            lpst_pkg::ST_FINISH:
            begin
                cmd.acc_en = avg_reg && !first_reg;
            end
            lpst_pkg::ST_EMIT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpst_pkg::ST_IDLE;
            count_reg     <= '0;
            first_reg     <= 1'b1;
            avg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/lpst_dp.sv =====
// datapath: soft threshold, decay multiply, saturating running sum, output register
module lpst_dp (
    input  logic                                  clk,
    input  lpst_pkg::cmd_t                        cmd,
    input  lpst_pkg::mode_t                       mode,
    input  logic [lpst_pkg::THRESH_W-1:0]         shrink_threshold,
    input  logic [lpst_pkg::DECAY_W-1:0]          decay_factor,
    input  logic signed [lpst_pkg::VALUE_W-1:0]   value_in,
    input  logic signed [lpst_pkg::VALUE_W-1:0]   add_term,
    output logic signed [lpst_pkg::VALUE_W-1:0]   value_out,
    output logic signed [lpst_pkg::SUM_W-1:0]     average_sum
);

    localparam int S_W = lpst_pkg::VALUE_W + 2;

    logic signed [lpst_pkg::VALUE_W-1:0] x_reg, x_next;
    logic signed [lpst_pkg::VALUE_W-1:0] c_reg;
    logic signed [lpst_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [lpst_pkg::MAG_W-1:0]          mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic signed [lpst_pkg::VALUE_W-1:0] value_out_reg;
    logic signed [lpst_pkg::SUM_W-1:0]   average_sum_reg;

    logic [lpst_pkg::THRESH_W-1:0] p_eff;
    logic [lpst_pkg::DECAY_W-1:0]  q_eff;
    logic signed [S_W-1:0]         s_val, p_pos, p_neg, s_lo, s_hi;
    logic [lpst_pkg::PROD_W-1:0]   prod;
    logic [lpst_pkg::SHIFT_W-1:0]  shifted;
    logic signed [lpst_pkg::SUM_W:0] sum_wide;

    // L2 drops the threshold, L1 and any factor above one use a unit decay
    always_comb
    begin
        p_eff = (mode == lpst_pkg::MODE_L2) ? '0 : shrink_threshold;
        if (mode == lpst_pkg::MODE_L1 || decay_factor > lpst_pkg::DECAY_ONE)
        begin
            q_eff = lpst_pkg::DECAY_ONE;
        end
        else
        begin
            q_eff = decay_factor;
        end
    end

    // soft threshold on x + c, kept as sign and magnitude
    always_comb
    begin
        s_val = S_W'(x_reg) + S_W'(c_reg);
        p_pos = S_W'({1'b0, p_eff});
        p_neg = -p_pos;
        s_hi  = s_val - p_pos;
        s_lo  = s_val + p_pos;
        if (s_val > p_pos)
        begin
            mag_next = s_hi[lpst_pkg::MAG_W-1:0];
            neg_next = 1'b0;
        end
        else if (s_val < p_neg)
        begin
            s_lo     = -s_lo;
            mag_next = s_lo[lpst_pkg::MAG_W-1:0];
            neg_next = 1'b1;
        end
        else
        begin
            mag_next = '0;
            neg_next = 1'b0;
        end
    end

    // magnitude times decay, cut toward zero, sign restored, saturated
    always_comb
    begin
        prod    = lpst_pkg::PROD_W'(mag_reg) * lpst_pkg::PROD_W'(q_eff);
        shifted = prod[lpst_pkg::PROD_W-1:lpst_pkg::FRAC_BITS];
        x_next  = x_reg;
        if (cmd.load)
        begin
            x_next = value_in;
        end
        else if (cmd.mul_en)
        begin
            if (!neg_reg)
            begin
                if (shifted > lpst_pkg::SHIFT_W'({1'b0, {(lpst_pkg::VALUE_W-1){1'b1}}}))
                begin
                    x_next = {1'b0, {(lpst_pkg::VALUE_W-1){1'b1}}};
                end
                else
                begin
                    x_next = shifted[lpst_pkg::VALUE_W-1:0];
                end
            end
            else
            begin
                if (shifted > lpst_pkg::SHIFT_W'({1'b1, {(lpst_pkg::VALUE_W-1){1'b0}}}))
                begin
                    x_next = {1'b1, {(lpst_pkg::VALUE_W-1){1'b0}}};
                end
                else
                begin
                    x_next = -shifted[lpst_pkg::VALUE_W-1:0];
                end
            end
        end
    end

    // running sum with saturation to the signed sum range
    always_comb
    begin
        sum_wide = {sum_reg[lpst_pkg::SUM_W-1], sum_reg}
                 + {{(lpst_pkg::SUM_W+1-lpst_pkg::VALUE_W){x_reg[lpst_pkg::VALUE_W-1]}}, x_reg};
        sum_next = sum_reg;
        if (cmd.load)
        begin
            sum_next = '0;
        end
        else if (cmd.acc_en)
        begin
            if (sum_wide[lpst_pkg::SUM_W] != sum_wide[lpst_pkg::SUM_W-1])
            begin
                sum_next = sum_wide[lpst_pkg::SUM_W]
                         ? {1'b1, {(lpst_pkg::SUM_W-1){1'b0}}}
                         : {1'b0, {(lpst_pkg::SUM_W-1){1'b1}}};
            end
            else
            begin
                sum_next = sum_wide[lpst_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        sum_reg <= sum_next;
        if (cmd.load)
        begin
            c_reg <= add_term;
        end
        if (cmd.soft_en)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.out_load)
        begin
            value_out_reg   <= x_reg;
            average_sum_reg <= sum_reg;
        end
    end

    assign value_out   = value_out_reg;
    assign average_sum = average_sum_reg;

endmodule

// ===== design/lazy_proximal_soft_threshold_core.sv =====
// top level: configuration registers, step sequencer and arithmetic datapath
//
// Applies repeat_count times the rule x = decay * soft(x + add_term, threshold) to one
// Q16.16 coordinate and returns the final value and, when want_average is set, the
// saturated sum of the value after every step. Each step runs through one shared
// shrink-and-multiply unit, first in the shrink state and then in the multiply state; the
// number of steps is the repeat count, capped at MAX_REPEAT, and zero when the mode is
// none. A finish state folds the last value into the sum before the result is offered.
// One item is in work at a time; the next input transfer is taken as soon as the result
// sits in the output register, even if it is not yet taken. Configuration writes go
// through cfg_valid/cfg_ready (always ready) and are to be made only while no item is
// in work.
module lazy_proximal_soft_threshold_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpst_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [lpst_pkg::VALUE_W-1:0]   value_in,
    input  logic signed [lpst_pkg::VALUE_W-1:0]   add_term,
    input  logic [lpst_pkg::REPEAT_W-1:0]         repeat_count,
    input  logic                                  want_average,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lpst_pkg::VALUE_W-1:0]   value_out,
    output logic signed [lpst_pkg::SUM_W-1:0]     average_sum
);

    lpst_pkg::mode_t                mode_reg, mode_next;
    logic [lpst_pkg::THRESH_W-1:0]  thresh_reg, thresh_next;
    logic [lpst_pkg::DECAY_W-1:0]   decay_reg, decay_next;
    lpst_pkg::cmd_t                 cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        thresh_next = thresh_reg;
        decay_next  = decay_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lpst_pkg::CFG_MODE:
                begin
                    mode_next = lpst_pkg::mode_t'(cfg_data[lpst_pkg::MODE_W-1:0]);
                end
                lpst_pkg::CFG_THRESH:
                begin
                    thresh_next = cfg_data[lpst_pkg::THRESH_W-1:0];
                end
                lpst_pkg::CFG_DECAY:
                begin
                    decay_next = cfg_data[lpst_pkg::DECAY_W-1:0];
                end
                default:
                begin
                    // unknown register index: write dropped
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lpst_pkg::MODE_NONE;
            thresh_reg <= '0;
            decay_reg  <= lpst_pkg::DECAY_ONE;
        end
        else
        begin
            mode_reg   <= mode_next;
            thresh_reg <= thresh_next;
            decay_reg  <= decay_next;
        end
    end

    lpst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .repeat_count (repeat_count),
        .want_average (want_average),
        .mode         (mode_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd)
    );

    lpst_dp u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .mode             (mode_reg),
        .shrink_threshold (thresh_reg),
        .decay_factor     (decay_reg),
        .value_in         (value_in),
        .add_term         (add_term),
        .value_out        (value_out),
        .average_sum      (average_sum)
    );

endmodule
